@@ design/prw_pkg.sv @@
// Shared constants and types for the particle resampling wheel.
`timescale 1ns / 1ps

package prw_pkg;

    // Command codes carried on cmd
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_START = 2'd1;
    localparam cmd_t CMD_DRAW  = 2'd2;

    // Result kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_DRAW    = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_PARTICLE_COUNT = 2'd0;
    localparam cfg_index_t CFG_RESAMPLE_FRAC  = 2'd1;
    localparam cfg_index_t CFG_CLOSURE_FRAC   = 2'd2;

    // Fixed field widths
    localparam int COUNT_W    = 7;
    localparam int FRAC_W     = 8;
    localparam int UNIFORM_W  = 16;
    localparam int CFG_DATA_W = 8;

    // Register reset values
    localparam logic [COUNT_W-1:0] PARTICLE_COUNT_RST = 7'd50;
    localparam logic [FRAC_W-1:0]  RESAMPLE_FRAC_RST  = 8'd128;
    localparam logic [FRAC_W-1:0]  CLOSURE_FRAC_RST   = 8'd77;

    // Digit consumed per cycle by the serial multiplier
    localparam int DIGIT_W = 8;

endpackage

@@ design/prw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module prw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/prw_mul.sv @@
// Digit-serial multiplier: one 8-bit digit of b per cycle, done pulse when finished.
`timescale 1ns / 1ps

module prw_mul
    import prw_pkg::*;
#(
    parameter int A_W = 69,
    parameter int B_W = 30
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [A_W-1:0] product
);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [A_W-1:0] a_reg, a_next;
    logic [B_W-1:0] b_reg, b_next;
    logic [A_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                acc_next = acc_reg + A_W'(a_reg * A_W'(b_reg[DIGIT_W-1:0]));
                a_next   = a_reg << DIGIT_W;
                b_next   = b_reg >> DIGIT_W;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ design/particle_resampling_wheel.sv @@
// Top level of the particle resampling wheel: loads, summary test and wheel draws.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; results come as a one-cycle
// done pulse and cannot be held off, so the receiver must take every word as it comes.
// A start item seeds the wheel index and clears beta without leaving idle. A load
// has two steps (store write and weight accumulation, then the square accumulation).
// The last load of a set adds the effective-sample-size test, worked on a digit-serial
// multiplier at 8 bits per cycle; a zero sum skips it. A draw runs an add step, then
// wheel steps, each one read of the weight memory (at most 4 * N advances past the
// starting entry).
// Configuration is taken at any time through cfg_valid/cfg_ready but must only change
// while the block is idle.

module particle_resampling_wheel
    import prw_pkg::*;
#(
    parameter int MAX_PARTICLES = 64,
    parameter int WEIGHT_BITS   = 24,
    localparam int IDX_W = $clog2(MAX_PARTICLES),
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1)
)(
    input  logic                   clk,
    input  logic                   rst_n,
    // item channel
    input  logic                   start,
    output logic                   busy,
    input  cmd_t                   cmd,
    input  logic [WEIGHT_BITS-1:0] weight,
    input  logic                   loop_closed,
    input  logic                   is_last,
    input  logic [UNIFORM_W-1:0]   uniform,
    // result channel
    output logic                   done,
    output logic                   kind,
    output logic [IDX_W-1:0]       selected_index,
    output logic                   resample_needed,
    output logic [IDX_W-1:0]       best_index,
    output logic [CNT_W-1:0]       closure_count,
    output logic                   localizing,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int TOT_W   = WEIGHT_BITS + IDX_W;
    localparam int SQ_W    = 2 * WEIGHT_BITS + IDX_W;
    localparam int PSQ_W   = 2 * WEIGHT_BITS;
    localparam int INC_W   = WEIGHT_BITS + 1;
    localparam int BETA_W  = WEIGHT_BITS + 2;
    localparam int STEP_W  = CNT_W + 2;
    localparam int SCALE_W = UNIFORM_W + INC_W;
    localparam int SEED_W  = UNIFORM_W + CNT_W;
    localparam int THR_W   = FRAC_W + CNT_W;
    localparam int LHS_W   = 2 * TOT_W + FRAC_W;
    localparam int RHS_W   = SQ_W + THR_W;
    localparam int PROD_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int B_W     = (TOT_W > THR_W) ? TOT_W : THR_W;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LOAD_SQ  = 3'd1;
    localparam logic [2:0] ST_SUM_L    = 3'd2;
    localparam logic [2:0] ST_SUM_R    = 3'd3;
    localparam logic [2:0] ST_DRAW_ADD = 3'd4;
    localparam logic [2:0] ST_WALK     = 3'd5;

    // configuration
    logic [COUNT_W-1:0] pcount_reg;
    logic [FRAC_W-1:0]  rfrac_reg;
    logic [FRAC_W-1:0]  cfrac_reg;

    // control and accumulators
    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       pos_reg, pos_next;
    logic [TOT_W-1:0]       total_reg, total_next;
    logic [SQ_W-1:0]        square_reg, square_next;
    logic [WEIGHT_BITS-1:0] max_reg, max_next;
    logic [IDX_W-1:0]       arg_reg, arg_next;
    logic [CNT_W-1:0]       clos_reg, clos_next;
    logic                   phase_reg, phase_next;
    logic [IDX_W-1:0]       wheel_reg, wheel_next;
    logic [BETA_W-1:0]      beta_reg, beta_next;
    logic                   last_reg, last_next;
    logic [PSQ_W-1:0]       prod_reg, prod_next;
    logic [INC_W-1:0]       inc_reg, inc_next;
    logic [IDX_W-1:0]       walk_idx_reg, walk_idx_next;
    logic [STEP_W-1:0]      steps_reg, steps_next;
    logic [PROD_W-1:0]      lhs_reg, lhs_next;

    // result word
    logic                   done_reg, done_next;
    logic                   kind_reg, kind_next;
    logic [IDX_W-1:0]       sel_reg, sel_next;
    logic                   resample_reg, resample_next;
    logic [IDX_W-1:0]       best_reg, best_next;
    logic [CNT_W-1:0]       closure_reg, closure_next;
    logic                   loc_reg, loc_next;

    logic [CNT_W-1:0]       n_active;
    logic                   accept;
    logic                   pos_in_range;
    logic [CNT_W-1:0]       idx_inc;
    logic [IDX_W-1:0]       idx_step;
    logic                   beta_over;
    logic                   walk_limit;
    logic                   closure_hit;
    logic                   phase_sum;
    logic [SEED_W-1:0]      seed_prod;
    logic [SCALE_W-1:0]     scale_prod;
    logic [PSQ_W-1:0]       weight_sq;
    logic [THR_W-1:0]       thr_prod;

    logic                   mem_we;
    logic [IDX_W-1:0]       rd_addr;
    logic [WEIGHT_BITS-1:0] rd_data;

    logic                   mul_start;
    logic [PROD_W-1:0]      mul_a;
    logic [B_W-1:0]         mul_b;
    logic                   mul_done;
    logic [PROD_W-1:0]      mul_product;

    prw_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_PARTICLES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (pos_reg[IDX_W-1:0]),
        .wdata (weight),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    prw_mul #(
        .A_W (PROD_W),
        .B_W (B_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= PARTICLE_COUNT_RST;
            rfrac_reg  <= RESAMPLE_FRAC_RST;
            cfrac_reg  <= CLOSURE_FRAC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PARTICLE_COUNT: pcount_reg <= cfg_data[COUNT_W-1:0];
                CFG_RESAMPLE_FRAC:  rfrac_reg  <= cfg_data[FRAC_W-1:0];
                CFG_CLOSURE_FRAC:   cfrac_reg  <= cfg_data[FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    // particle count clamped to 1..MAX_PARTICLES
    always_comb
    begin
        if (pcount_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(pcount_reg) > MAX_PARTICLES)
        begin
            n_active = CNT_W'(MAX_PARTICLES);
        end
        else
        begin
            n_active = CNT_W'(pcount_reg);
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign pos_in_range = (pos_reg < n_active);
    assign idx_inc      = CNT_W'(walk_idx_reg) + CNT_W'(1);
    assign idx_step     = (idx_inc == n_active) ? '0 : idx_inc[IDX_W-1:0];
    assign beta_over    = (beta_reg > BETA_W'(rd_data));
    assign walk_limit   = (steps_reg >= {n_active, 2'b00});
    assign closure_hit  = ((THR_W'(clos_reg) << FRAC_W) >
                           (THR_W'(n_active) * THR_W'(cfrac_reg)));
    assign phase_sum    = phase_reg | closure_hit;
    assign seed_prod    = SEED_W'(uniform) * SEED_W'(n_active);
    // beta step is uniform * 2 * max / 2^16
    assign scale_prod   = SCALE_W'(uniform) * SCALE_W'({max_reg, 1'b0});
    assign weight_sq    = PSQ_W'(weight) * PSQ_W'(weight);
    assign thr_prod     = THR_W'(rfrac_reg) * THR_W'(n_active);

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        total_next    = total_reg;
        square_next   = square_reg;
        max_next      = max_reg;
        arg_next      = arg_reg;
        clos_next     = clos_reg;
        phase_next    = phase_reg;
        wheel_next    = wheel_reg;
        beta_next     = beta_reg;
        last_next     = last_reg;
        prod_next     = prod_reg;
        inc_next      = inc_reg;
        walk_idx_next = walk_idx_reg;
        steps_next    = steps_reg;
        lhs_next      = lhs_reg;
        done_next     = 1'b0;
        kind_next     = kind_reg;
        sel_next      = sel_reg;
        resample_next = resample_reg;
        best_next     = best_reg;
        closure_next  = closure_reg;
        loc_next      = loc_reg;
        mem_we        = 1'b0;
        rd_addr       = walk_idx_reg;
        mul_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_LOAD:
                        begin
                            // first load of a set starts the statistics afresh
                            if (pos_reg == '0)
                            begin
                                total_next  = '0;
                                square_next = '0;
                                max_next    = '0;
                                arg_next    = '0;
                                clos_next   = '0;
                            end
                            prod_next = '0;
                            if (pos_in_range)
                            begin
                                mem_we     = 1'b1;
                                total_next = total_next + TOT_W'(weight);
                                prod_next  = weight_sq;
                                if (weight > max_next)
                                begin
                                    max_next = weight;
                                    arg_next = pos_reg[IDX_W-1:0];
                                end
                                clos_next = clos_next + CNT_W'(loop_closed);
                                pos_next  = pos_reg + CNT_W'(1);
                            end
                            last_next = is_last;
                            if (is_last)
                            begin
                                pos_next = '0;
                            end
                            state_next = ST_LOAD_SQ;
                        end
                        CMD_START:
                        begin
                            wheel_next = seed_prod[UNIFORM_W +: IDX_W];
                            beta_next  = '0;
                        end
                        CMD_DRAW:
                        begin
                            inc_next = scale_prod[UNIFORM_W +: INC_W];
                            if (CNT_W'(wheel_reg) >= n_active)
                            begin
                                walk_idx_next = '0;
                            end
                            else
                            begin
                                walk_idx_next = wheel_reg;
                            end
                            steps_next = '0;
                            state_next = ST_DRAW_ADD;
                        end
                        default: ;
                    endcase
                end
            end

            ST_LOAD_SQ:
            begin
                square_next = square_reg + SQ_W'(prod_reg);
                state_next  = ST_IDLE;
                if (last_reg)
                begin
                    phase_next = phase_sum;
                    if (total_reg == '0)
                    begin
                        done_next     = 1'b1;
                        kind_next     = KIND_SUMMARY;
                        sel_next      = '0;
                        resample_next = 1'b1;
                        best_next     = arg_reg;
                        closure_next  = clos_reg;
                        loc_next      = phase_sum;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = PROD_W'(total_reg);
                        mul_b      = B_W'(total_reg);
                        state_next = ST_SUM_L;
                    end
                end
            end

            ST_SUM_L:
            begin
                if (mul_done)
                begin
                    // sum squared, scaled by 256 to match the Q0.8 fraction
                    lhs_next   = mul_product << FRAC_W;
                    mul_start  = 1'b1;
                    mul_a      = PROD_W'(square_reg);
                    mul_b      = B_W'(thr_prod);
                    state_next = ST_SUM_R;
                end
            end

            ST_SUM_R:
            begin
                if (mul_done)
                begin
                    done_next     = 1'b1;
                    kind_next     = KIND_SUMMARY;
                    sel_next      = '0;
                    resample_next = (lhs_reg < mul_product);
                    best_next     = arg_reg;
                    closure_next  = clos_reg;
                    loc_next      = phase_reg;
                    state_next    = ST_IDLE;
                end
            end

            ST_DRAW_ADD:
            begin
                beta_next  = beta_reg + BETA_W'(inc_reg);
                rd_addr    = walk_idx_reg;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                // prefetch the next entry; used only if the walk goes on
                rd_addr = idx_step;
                if (beta_over && !walk_limit)
                begin
                    beta_next     = beta_reg - BETA_W'(rd_data);
                    walk_idx_next = idx_step;
                    steps_next    = steps_reg + STEP_W'(1);
                end
                else
                begin
                    if (beta_over)
                    begin
                        beta_next = '0;
                    end
                    wheel_next    = walk_idx_reg;
                    done_next     = 1'b1;
                    kind_next     = KIND_DRAW;
                    sel_next      = walk_idx_reg;
                    resample_next = 1'b0;
                    best_next     = '0;
                    closure_next  = '0;
                    loc_next      = phase_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            total_reg  <= '0;
            square_reg <= '0;
            max_reg    <= '0;
            arg_reg    <= '0;
            clos_reg   <= '0;
            phase_reg  <= 1'b0;
            wheel_reg  <= '0;
            beta_reg   <= '0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            square_reg <= square_next;
            max_reg    <= max_next;
            arg_reg    <= arg_next;
            clos_reg   <= clos_next;
            phase_reg  <= phase_next;
            wheel_reg  <= wheel_next;
            beta_reg   <= beta_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        inc_reg      <= inc_next;
        walk_idx_reg <= walk_idx_next;
        steps_reg    <= steps_next;
        lhs_reg      <= lhs_next;
        kind_reg     <= kind_next;
        sel_reg      <= sel_next;
        resample_reg <= resample_next;
        best_reg     <= best_next;
        closure_reg  <= closure_next;
        loc_reg      <= loc_next;
    end

    assign done            = done_reg;
    assign kind            = kind_reg;
    assign selected_index  = sel_reg;
    assign resample_needed = resample_reg;
    assign best_index      = best_reg;
    assign closure_count   = closure_reg;
    assign localizing      = loc_reg;

    // a load or draw always leaves the idle state
    a_work_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_LOAD || cmd == CMD_DRAW)) |=> busy)
        else $error("load or draw accepted but block not busy");

    // the wheel walk never passes its step bound
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (steps_reg <= {n_active, 2'b00}))
        else $error("wheel walk exceeded step bound");

    // a non-zero sum gives a non-zero left-hand side for the test
    a_lhs_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM_R) |-> (lhs_reg != '0))
        else $error("zero sum reached the resample compare");

    // results never come on consecutive cycles
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule
